>>> hdl/dda_pkg.sv
// Shared constants and codes for the line point stepper.
`default_nettype none

package dda_pkg;

    // Default coordinate width and fixed tag width
    localparam int COORD_BITS_DEF = 10;
    localparam int MATERIAL_BITS  = 8;

    // Function codes of an input word
    typedef enum logic {
        t_FUNC_LOAD = 1'b0,
        t_FUNC_STEP = 1'b1
    } t_func;

endpackage

`default_nettype wire

>>> hdl/dda_in_stage.sv
// Input register: holds one incoming word until the core takes it.
`default_nettype none

module dda_in_stage #(
    parameter int COORD_BITS = dda_pkg::COORD_BITS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // upstream side
    input  wire logic                           i_valid,
    output      logic                           o_ready,
    input  wire logic                           i_func,
    input  wire logic [COORD_BITS-1:0]          i_x_start,
    input  wire logic [COORD_BITS-1:0]          i_y_start,
    input  wire logic [COORD_BITS-1:0]          i_x_end,
    input  wire logic [COORD_BITS-1:0]          i_y_end,
    input  wire logic [dda_pkg::MATERIAL_BITS-1:0] i_material,
    // core side
    input  wire logic                           i_take,
    output      logic                           o_item_valid,
    output      logic                           o_func,
    output      logic [COORD_BITS-1:0]          o_x_start,
    output      logic [COORD_BITS-1:0]          o_y_start,
    output      logic [COORD_BITS-1:0]          o_x_end,
    output      logic [COORD_BITS-1:0]          o_y_end,
    output      logic [dda_pkg::MATERIAL_BITS-1:0] o_material
);
    import dda_pkg::*;

    logic                     r_valid;
    logic                     r_func;
    logic [COORD_BITS-1:0]    r_x_start, r_y_start, r_x_end, r_y_end;
    logic [MATERIAL_BITS-1:0] r_material;

    // Free when empty or when the held word leaves this cycle
    assign o_ready = !r_valid || i_take;

    // Valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_func     <= i_func;
            r_x_start  <= i_x_start;
            r_y_start  <= i_y_start;
            r_x_end    <= i_x_end;
            r_y_end    <= i_y_end;
            r_material <= i_material;
        end
    end

    assign o_item_valid = r_valid;
    assign o_func       = r_func;
    assign o_x_start    = r_x_start;
    assign o_y_start    = r_y_start;
    assign o_x_end      = r_x_end;
    assign o_y_end      = r_y_end;
    assign o_material   = r_material;

endmodule

`default_nettype wire

>>> hdl/dda_core.sv
// Line state and next point: one load or step per cycle, a step needs room.
`default_nettype none

module dda_core #(
    parameter int COORD_BITS = dda_pkg::COORD_BITS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_item_valid,
    input  wire logic                           i_out_free,
    input  wire logic                           i_func,
    input  wire logic [COORD_BITS-1:0]          i_x_start,
    input  wire logic [COORD_BITS-1:0]          i_y_start,
    input  wire logic [COORD_BITS-1:0]          i_x_end,
    input  wire logic [COORD_BITS-1:0]          i_y_end,
    input  wire logic [dda_pkg::MATERIAL_BITS-1:0] i_material,
    output      logic                           o_take,
    output      logic                           o_push,
    output      logic                           o_valid_res,
    output      logic [COORD_BITS-1:0]          o_point_x,
    output      logic [COORD_BITS-1:0]          o_point_y,
    output      logic [dda_pkg::MATERIAL_BITS-1:0] o_point_material,
    output      logic                           o_final_point
);
    import dda_pkg::*;

    localparam int LW = COORD_BITS + 1;   // length, count, offset
    localparam int EW = COORD_BITS + 2;   // error term

    logic                     r_line_active, r_steep_mode, r_major_sign;
    logic [COORD_BITS-1:0]    r_origin_x, r_origin_y;
    logic [LW-1:0]            r_major_length, r_step_count;
    logic signed [LW-1:0]     r_minor_delta, r_minor_offset;
    logic signed [EW-1:0]     r_error_term;
    logic [MATERIAL_BITS-1:0] r_line_material;

    logic                     is_load, is_step;
    logic signed [LW-1:0]     dx, dy;
    logic [LW-1:0]            adx, ady;
    logic                     ld_steep;
    logic [LW-1:0]            omaj, omin, maj_sum;
    logic signed [LW-1:0]     mnr_sum;
    logic                     done, last;
    logic signed [EW-1:0]     err_sum, len_ext;

    // Handshake: a load never produces a word, a step needs room downstream
    assign is_load = i_item_valid && (i_func == t_FUNC_LOAD);
    assign is_step = i_item_valid && (i_func == t_FUNC_STEP) && i_out_free;
    assign o_take  = is_load || is_step;
    assign o_push  = is_step;

    // Load: deltas and major axis choice (ties go to x)
    always_comb begin
        dx       = $signed({1'b0, i_x_end}) - $signed({1'b0, i_x_start});
        dy       = $signed({1'b0, i_y_end}) - $signed({1'b0, i_y_start});
        adx      = dx[LW-1] ? LW'(-dx) : LW'(dx);
        ady      = dy[LW-1] ? LW'(-dy) : LW'(dy);
        ld_steep = ady > adx;
    end

    // Step: current point and next error term
    always_comb begin
        omaj    = r_steep_mode ? {1'b0, r_origin_y} : {1'b0, r_origin_x};
        omin    = r_steep_mode ? {1'b0, r_origin_x} : {1'b0, r_origin_y};
        maj_sum = r_major_sign ? (omaj - r_step_count) : (omaj + r_step_count);
        mnr_sum = $signed(omin) + r_minor_offset;
        done    = !r_line_active || (r_step_count >= r_major_length);
        last    = r_step_count == (r_major_length - LW'(1));
        err_sum = r_error_term + {r_minor_delta[LW-1], r_minor_delta};
        len_ext = $signed({1'b0, r_major_length});
    end

    // Result fields, zero when the line is finished
    always_comb begin
        o_valid_res      = !done;
        o_point_x        = '0;
        o_point_y        = '0;
        o_point_material = '0;
        o_final_point    = 1'b0;
        if (!done) begin
            o_point_x        = r_steep_mode ? mnr_sum[COORD_BITS-1:0]
                                            : maj_sum[COORD_BITS-1:0];
            o_point_y        = r_steep_mode ? maj_sum[COORD_BITS-1:0]
                                            : mnr_sum[COORD_BITS-1:0];
            o_point_material = r_line_material;
            o_final_point    = last;
        end
    end

    // Line state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_active   <= 1'b0;
            r_steep_mode    <= 1'b0;
            r_major_sign    <= 1'b0;
            r_origin_x      <= '0;
            r_origin_y      <= '0;
            r_major_length  <= '0;
            r_minor_delta   <= '0;
            r_step_count    <= '0;
            r_minor_offset  <= '0;
            r_error_term    <= '0;
            r_line_material <= '0;
        end else if (is_load) begin
            r_origin_x      <= i_x_start;
            r_origin_y      <= i_y_start;
            r_line_material <= i_material;
            r_steep_mode    <= ld_steep;
            r_major_sign    <= ld_steep ? dy[LW-1] : dx[LW-1];
            r_major_length  <= ld_steep ? ady : adx;
            r_minor_delta   <= ld_steep ? dx : dy;
            r_step_count    <= '0;
            r_minor_offset  <= '0;
            r_error_term    <= '0;
            r_line_active   <= ld_steep ? (ady != '0) : (adx != '0);
        end else if (is_step) begin
            if (done) begin
                r_line_active <= 1'b0;
            end else begin
                r_step_count <= r_step_count + LW'(1);
                if (err_sum >= len_ext) begin
                    r_error_term   <= err_sum - len_ext;
                    r_minor_offset <= r_minor_offset + LW'(1);
                end else if (err_sum < 0) begin
                    r_error_term   <= err_sum + len_ext;
                    r_minor_offset <= r_minor_offset - LW'(1);
                end else begin
                    r_error_term   <= err_sum;
                end
                if (last) begin
                    r_line_active <= 1'b0;
                end
            end
        end
    end

    // Checks on the line state
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_step_count <= r_major_length)
        else $error("step count ran past line length");

    a_error_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_line_active |-> (r_error_term >= 0) && (r_error_term < len_ext))
        else $error("error term out of range");

    a_zero_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (is_load && (i_x_start == i_x_end) && (i_y_start == i_y_end))
        |=> !r_line_active)
        else $error("zero-length line left active");

endmodule

`default_nettype wire

>>> hdl/dda_out_stage.sv
// Result register: holds one result word until downstream takes it.
`default_nettype none

module dda_out_stage #(
    parameter int COORD_BITS = dda_pkg::COORD_BITS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_push,
    input  wire logic                           i_valid_res,
    input  wire logic [COORD_BITS-1:0]          i_point_x,
    input  wire logic [COORD_BITS-1:0]          i_point_y,
    input  wire logic [dda_pkg::MATERIAL_BITS-1:0] i_point_material,
    input  wire logic                           i_final_point,
    output      logic                           o_free,
    output      logic                           o_valid,
    input  wire logic                           i_ready,
    output      logic                           o_valid_res,
    output      logic [COORD_BITS-1:0]          o_point_x,
    output      logic [COORD_BITS-1:0]          o_point_y,
    output      logic [dda_pkg::MATERIAL_BITS-1:0] o_point_material,
    output      logic                           o_final_point
);
    import dda_pkg::*;

    logic                     r_valid;
    logic                     r_valid_res, r_final_point;
    logic [COORD_BITS-1:0]    r_point_x, r_point_y;
    logic [MATERIAL_BITS-1:0] r_point_material;

    // Room for a new word when empty or being drained
    assign o_free = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_push;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push && o_free) begin
            r_valid_res      <= i_valid_res;
            r_point_x        <= i_point_x;
            r_point_y        <= i_point_y;
            r_point_material <= i_point_material;
            r_final_point    <= i_final_point;
        end
    end

    assign o_valid          = r_valid;
    assign o_valid_res      = r_valid_res;
    assign o_point_x        = r_point_x;
    assign o_point_y        = r_point_y;
    assign o_point_material = r_point_material;
    assign o_final_point    = r_final_point;

    // The core only pushes when there is room
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> o_free)
        else $error("result word overwritten");

    // A finished-line word carries zero fields
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_valid_res) |-> (o_point_x == '0) && (o_point_y == '0)
            && (o_point_material == '0) && !o_final_point)
        else $error("empty result with nonzero fields");

endmodule

`default_nettype wire

>>> hdl/dda_line_point_stepper_top.sv
// Top level of the DDA line point stepper.
//
//  channel   direction  handshake          fields
//  input     in         i_valid / o_ready  i_func, i_x_start, i_y_start, i_x_end,
//                                          i_y_end, i_material
//  result    out        o_valid / i_ready  o_valid_res, o_point_x, o_point_y,
//                                          o_point_material, o_final_point
//
// One word per cycle while the result side is not stalled; a step word passes the
// input register, then the state update writes the result register.
// A load word gives no result; each step word gives exactly one.
// The incremental error update (one add, one compare, one correction) sets the
// per-cycle path. Reset is synchronous and clears the line state (no line).
// A stall on the result side holds the result register, then the input register.
`default_nettype none

module dda_line_point_stepper_top #(
    parameter int COORD_BITS = dda_pkg::COORD_BITS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    output      logic                           o_ready,
    input  wire logic                           i_func,
    input  wire logic [COORD_BITS-1:0]          i_x_start,
    input  wire logic [COORD_BITS-1:0]          i_y_start,
    input  wire logic [COORD_BITS-1:0]          i_x_end,
    input  wire logic [COORD_BITS-1:0]          i_y_end,
    input  wire logic [dda_pkg::MATERIAL_BITS-1:0] i_material,
    output      logic                           o_valid,
    input  wire logic                           i_ready,
    output      logic                           o_valid_res,
    output      logic [COORD_BITS-1:0]          o_point_x,
    output      logic [COORD_BITS-1:0]          o_point_y,
    output      logic [dda_pkg::MATERIAL_BITS-1:0] o_point_material,
    output      logic                           o_final_point
);
    import dda_pkg::*;

    logic                     item_valid, item_func, take, push, out_free;
    logic [COORD_BITS-1:0]    item_xs, item_ys, item_xe, item_ye;
    logic [MATERIAL_BITS-1:0] item_mat;
    logic                     res_valid, res_final;
    logic [COORD_BITS-1:0]    res_x, res_y;
    logic [MATERIAL_BITS-1:0] res_mat;

    dda_in_stage #(.COORD_BITS(COORD_BITS)) u_in (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_func       (i_func),
        .i_x_start    (i_x_start),
        .i_y_start    (i_y_start),
        .i_x_end      (i_x_end),
        .i_y_end      (i_y_end),
        .i_material   (i_material),
        .i_take       (take),
        .o_item_valid (item_valid),
        .o_func       (item_func),
        .o_x_start    (item_xs),
        .o_y_start    (item_ys),
        .o_x_end      (item_xe),
        .o_y_end      (item_ye),
        .o_material   (item_mat)
    );

    dda_core #(.COORD_BITS(COORD_BITS)) u_core (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_item_valid     (item_valid),
        .i_out_free       (out_free),
        .i_func           (item_func),
        .i_x_start        (item_xs),
        .i_y_start        (item_ys),
        .i_x_end          (item_xe),
        .i_y_end          (item_ye),
        .i_material       (item_mat),
        .o_take           (take),
        .o_push           (push),
        .o_valid_res      (res_valid),
        .o_point_x        (res_x),
        .o_point_y        (res_y),
        .o_point_material (res_mat),
        .o_final_point    (res_final)
    );

    dda_out_stage #(.COORD_BITS(COORD_BITS)) u_out (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_push           (push),
        .i_valid_res      (res_valid),
        .i_point_x        (res_x),
        .i_point_y        (res_y),
        .i_point_material (res_mat),
        .i_final_point    (res_final),
        .o_free           (out_free),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_valid_res      (o_valid_res),
        .o_point_x        (o_point_x),
        .o_point_y        (o_point_y),
        .o_point_material (o_point_material),
        .o_final_point    (o_final_point)
    );

endmodule

`default_nettype wire

>>> verif/tb_dda_line_point_stepper_top.sv
// Testbench for the DDA line point stepper: directed table, then random line sequences.
`default_nettype none

module tb_dda_line_point_stepper_top;
    timeunit 1ns;
    timeprecision 1ps;

    import dda_pkg::*;

    localparam int CW           = COORD_BITS_DEF;
    localparam int MW           = MATERIAL_BITS;
    localparam int CMAX         = (1 << CW) - 1;
    localparam int WORD_TOTAL   = 650;
    localparam int HOLD_LEN     = 80;
    localparam int DRAIN_CYCLES = 20;
    localparam int LIMIT_CYCLES = 300000;
    localparam int PRINT_CAP    = 40;

    // One result word as seen on the output side
    typedef struct packed {
        logic          valid_res;
        logic [CW-1:0] px;
        logic [CW-1:0] py;
        logic [MW-1:0] mat;
        logic          last_pt;
    } point_t;

    // One input word, with an optional hand-written expectation
    typedef struct {
        t_func         op;
        logic [CW-1:0] xs;
        logic [CW-1:0] ys;
        logic [CW-1:0] xe;
        logic [CW-1:0] ye;
        logic [MW-1:0] mat;
        bit            typed;
        point_t        want;
    } line_word_t;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          i_valid = 1'b0;
    logic          o_ready;
    t_func         i_func = t_FUNC_LOAD;
    logic [CW-1:0] i_x_start = '0;
    logic [CW-1:0] i_y_start = '0;
    logic [CW-1:0] i_x_end = '0;
    logic [CW-1:0] i_y_end = '0;
    logic [MW-1:0] i_material = '0;
    logic          o_valid;
    logic          i_ready = 1'b0;
    logic          o_valid_res;
    logic [CW-1:0] o_point_x;
    logic [CW-1:0] o_point_y;
    logic [MW-1:0] o_point_material;
    logic          o_final_point;

    dda_line_point_stepper_top #(.COORD_BITS(CW)) uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_func           (i_func),
        .i_x_start        (i_x_start),
        .i_y_start        (i_y_start),
        .i_x_end          (i_x_end),
        .i_y_end          (i_y_end),
        .i_material       (i_material),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_valid_res      (o_valid_res),
        .o_point_x        (o_point_x),
        .o_point_y        (o_point_y),
        .o_point_material (o_point_material),
        .o_final_point    (o_final_point)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Line predictor state
    logic                 ln_active;
    logic                 ln_steep;
    logic [CW-1:0]        org_x;
    logic [CW-1:0]        org_y;
    logic                 maj_neg;
    logic [CW:0]          maj_len;
    logic signed [CW:0]   min_dlt;
    logic [CW:0]          steps_done;
    logic signed [CW:0]   min_off;
    logic signed [CW+1:0] err_acc;
    logic [MW-1:0]        ln_mat;

    point_t     expected_points[$];
    line_word_t cur_word;
    int         fail_count;
    int         cycle_count;
    int         hold_cycles;
    int         burst_left;
    int         words_sent;
    int         n_loads;
    int         n_steps;
    int         n_points;
    int         n_empty;
    int         n_final;

    // Advance the predicted line by one accepted word
    task automatic advance_line(input line_word_t w, output bit has_pt, output point_t pt);
        int dx, dy, adx, ady;
        int omaj, omin, maj, mnr, e, off;
        pt = '0;
        has_pt = 1'b0;
        if (w.op == t_FUNC_LOAD) begin
            dx = int'(w.xe) - int'(w.xs);
            dy = int'(w.ye) - int'(w.ys);
            adx = dx < 0 ? -dx : dx;
            ady = dy < 0 ? -dy : dy;
            org_x = w.xs;
            org_y = w.ys;
            ln_mat = w.mat;
            // ties go to x as the major axis
            if (adx >= ady) begin
                ln_steep = 1'b0;
                maj_neg = dx < 0;
                maj_len = (CW+1)'(adx);
                min_dlt = (CW+1)'(dy);
            end else begin
                ln_steep = 1'b1;
                maj_neg = dy < 0;
                maj_len = (CW+1)'(ady);
                min_dlt = (CW+1)'(dx);
            end
            steps_done = '0;
            min_off = '0;
            err_acc = '0;
            ln_active = maj_len != 0;
            return;
        end
        has_pt = 1'b1;
        if (!ln_active || steps_done >= maj_len) begin
            ln_active = 1'b0;
            return;
        end
        omaj = ln_steep ? int'(org_y) : int'(org_x);
        omin = ln_steep ? int'(org_x) : int'(org_y);
        maj = maj_neg ? omaj - int'(steps_done) : omaj + int'(steps_done);
        mnr = omin + int'(min_off);
        pt.valid_res = 1'b1;
        pt.px = ln_steep ? mnr[CW-1:0] : maj[CW-1:0];
        pt.py = ln_steep ? maj[CW-1:0] : mnr[CW-1:0];
        pt.mat = ln_mat;
        pt.last_pt = steps_done == maj_len - 1;
        // exact error term keeps minor = floor(k*dminor/|dmajor|)
        e = int'(err_acc) + int'(min_dlt);
        off = int'(min_off);
        if (e >= int'(maj_len)) begin
            e = e - int'(maj_len);
            off = off + 1;
        end else if (e < 0) begin
            e = e + int'(maj_len);
            off = off - 1;
        end
        err_acc = (CW+2)'(e);
        min_off = (CW+1)'(off);
        steps_done = steps_done + 1'b1;
        if (pt.last_pt)
            ln_active = 1'b0;
    endtask

    // One line per mismatch; printing is capped, counting is not
    task automatic report_mismatch(input string what, input int got, input int want);
        fail_count++;
        if (fail_count <= PRINT_CAP)
            $display("%0t ns: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    // Word builders
    function automatic line_word_t load_word(int xs, int ys, int xe, int ye, int mat);
        line_word_t w;
        w.op = t_FUNC_LOAD;
        w.xs = xs[CW-1:0];
        w.ys = ys[CW-1:0];
        w.xe = xe[CW-1:0];
        w.ye = ye[CW-1:0];
        w.mat = mat[MW-1:0];
        w.typed = 1'b0;
        w.want = '0;
        return w;
    endfunction

    function automatic line_word_t step_word(bit typed, bit v, int x, int y, int m, bit l);
        line_word_t w;
        w = load_word($urandom_range(CMAX), $urandom_range(CMAX), $urandom_range(CMAX),
                      $urandom_range(CMAX), $urandom_range(255));
        w.op = t_FUNC_STEP;
        w.typed = typed;
        w.want = '{valid_res: v, px: x[CW-1:0], py: y[CW-1:0], mat: m[MW-1:0], last_pt: l};
        return w;
    endfunction

    // Random coordinate within span of c, clipped to the field range
    function automatic int near(int c, int span);
        int lo, hi;
        lo = c - span < 0 ? 0 : c - span;
        hi = c + span > CMAX ? CMAX : c + span;
        return $urandom_range(hi, lo);
    endfunction

    // Offer one word in bursts with random gaps, wait for the handshake
    task automatic send_word(input line_word_t w);
        int gap;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(24, 1);
            if ($urandom_range(3) != 0)
                gap = $urandom_range(6, 1);
        end
        burst_left--;
        if (hold_cycles > 0)
            gap = 0;
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        cur_word = w;
        i_valid <= 1'b1;
        i_func <= w.op;
        i_x_start <= w.xs;
        i_y_start <= w.ys;
        i_x_end <= w.xe;
        i_y_end <= w.ye;
        i_material <= w.mat;
        do @(posedge i_clk); while (o_ready !== 1'b1);
        words_sent++;
    endtask

    // Drop valid and hold until every expected word has come back
    task automatic drain_pause();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (expected_points.size() != 0)
            @(posedge i_clk);
        repeat ($urandom_range(12, 3)) @(negedge i_clk);
    endtask

    // Receiver: own stall pattern, plus a counted long hold-off on request
    initial begin
        int mode_left;
        int stall_pct;
        mode_left = 0;
        stall_pct = 0;
        forever begin
            @(negedge i_clk);
            if (hold_cycles > 0) begin
                i_ready <= 1'b0;
                hold_cycles--;
            end else begin
                if (mode_left == 0) begin
                    mode_left = $urandom_range(60, 10);
                    case ($urandom_range(4))
                        0, 1:    stall_pct = 0;
                        2:       stall_pct = 20;
                        3:       stall_pct = 50;
                        default: stall_pct = 85;
                    endcase
                end
                mode_left--;
                i_ready <= $urandom_range(99) >= stall_pct;
            end
        end
    end

    // Predict on input handshakes, check on output handshakes
    always @(posedge i_clk) begin
        bit     has_pt;
        point_t pt;
        point_t want;
        if (i_rst_n) begin
            if (i_valid === 1'b1 && o_ready === 1'b1) begin
                advance_line(cur_word, has_pt, pt);
                if (cur_word.op == t_FUNC_LOAD)
                    n_loads++;
                else
                    n_steps++;
                if (has_pt)
                    expected_points.push_back(cur_word.typed ? cur_word.want : pt);
            end
            if (o_valid === 1'b1 && i_ready === 1'b1) begin
                if (expected_points.size() == 0) begin
                    report_mismatch("unexpected result word", o_point_x, -1);
                end else begin
                    want = expected_points.pop_front();
                    if (o_valid_res !== want.valid_res)
                        report_mismatch("valid_res", o_valid_res, want.valid_res);
                    if (o_point_x !== want.px)
                        report_mismatch("point_x", o_point_x, want.px);
                    if (o_point_y !== want.py)
                        report_mismatch("point_y", o_point_y, want.py);
                    if (o_point_material !== want.mat)
                        report_mismatch("point_material", o_point_material, want.mat);
                    if (o_final_point !== want.last_pt)
                        report_mismatch("final_point", o_final_point, want.last_pt);
                    if (want.valid_res)
                        n_points++;
                    else
                        n_empty++;
                    if (want.last_pt)
                        n_final++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        line_word_t directed_tbl[$];
        line_word_t w;
        int xs, ys, xe, ye, len, nsteps, shape;
        bit hold_done;
        bit pause_done;

        ln_active = 1'b0;
        ln_steep = 1'b0;
        org_x = '0;
        org_y = '0;
        maj_neg = 1'b0;
        maj_len = '0;
        min_dlt = '0;
        steps_done = '0;
        min_off = '0;
        err_acc = '0;
        ln_mat = '0;
        fail_count = 0;
        cycle_count = 0;
        hold_cycles = 0;
        burst_left = 0;
        words_sent = 0;
        n_loads = 0;
        n_steps = 0;
        n_points = 0;
        n_empty = 0;
        n_final = 0;
        hold_done = 1'b0;
        pause_done = 1'b0;
        cur_word = load_word(0, 0, 0, 0, 0);

        // Directed table: typed rows are read straight off the line rules
        directed_tbl.push_back(step_word(1, 0, 0, 0, 0, 0));          // step with no line
        directed_tbl.push_back(load_word(5, 5, 5, 5, 'hAA));          // zero-length line
        directed_tbl.push_back(step_word(1, 0, 0, 0, 0, 0));
        directed_tbl.push_back(load_word(CMAX, CMAX, CMAX - 1, CMAX, 'hFF));
        directed_tbl.push_back(step_word(1, 1, CMAX, CMAX, 'hFF, 1)); // single point, last
        directed_tbl.push_back(step_word(1, 0, 0, 0, 0, 0));          // finished line
        directed_tbl.push_back(load_word(0, 0, CMAX, CMAX, 'h00));    // diagonal tie
        directed_tbl.push_back(step_word(1, 1, 0, 0, 'h00, 0));
        directed_tbl.push_back(step_word(0, 0, 0, 0, 0, 0));
        directed_tbl.push_back(load_word(0, CMAX, CMAX, 0, 'h55));    // tie, falling minor
        directed_tbl.push_back(step_word(1, 1, 0, CMAX, 'h55, 0));
        directed_tbl.push_back(step_word(0, 0, 0, 0, 0, 0));
        directed_tbl.push_back(load_word(512, 0, 515, CMAX, 'h3C));   // steep, full height
        repeat (3) directed_tbl.push_back(step_word(0, 0, 0, 0, 0, 0));
        directed_tbl.push_back(load_word(700, 900, 300, 100, 'hC3));  // reload mid-line
        repeat (3) directed_tbl.push_back(step_word(0, 0, 0, 0, 0, 0));
        directed_tbl.push_back(load_word(10, 20, 13, 22, 'h01));      // short line to the end
        repeat (4) directed_tbl.push_back(step_word(0, 0, 0, 0, 0, 0));

        // Hold synchronous reset, then release it
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_tbl[i])
            send_word(directed_tbl[i]);
        drain_pause();

        // Random part: mostly load-then-step sequences, some noise
        while (words_sent < WORD_TOTAL) begin
            if (!hold_done && words_sent >= 200) begin
                hold_cycles = HOLD_LEN;
                hold_done = 1'b1;
            end
            if (!pause_done && words_sent >= 420) begin
                drain_pause();
                pause_done = 1'b1;
            end
            if ($urandom_range(99) < 8) begin
                w = step_word(0, 0, 0, 0, 0, 0);
                if ($urandom_range(1))
                    w.op = t_FUNC_LOAD;
                send_word(w);
            end else begin
                xs = $urandom_range(CMAX);
                ys = $urandom_range(CMAX);
                shape = $urandom_range(9);
                if (shape < 7) begin
                    xe = near(xs, 12);
                    ye = near(ys, 12);
                end else if (shape < 9) begin
                    xe = near(xs, 64);
                    ye = near(ys, 64);
                end else begin
                    xe = $urandom_range(CMAX);
                    ye = $urandom_range(CMAX);
                end
                len = (xe > xs ? xe - xs : xs - xe);
                if ((ye > ys ? ye - ys : ys - ye) > len)
                    len = ye > ys ? ye - ys : ys - ye;
                // long lines are cut off by the next load; a few short ones get a random step count
                if (len > 70 || $urandom_range(6) == 0)
                    nsteps = $urandom_range(20, 0);
                else
                    nsteps = len + $urandom_range(2);
                send_word(load_word(xs, ys, xe, ye, $urandom_range(255)));
                repeat (nsteps) send_word(step_word(0, 0, 0, 0, 0, 0));
            end
        end

        @(negedge i_clk);
        i_valid <= 1'b0;
        while (expected_points.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d load words and %0d step words over %0d cycles.",
                 n_loads, n_steps, cycle_count);
        $display("Checked %0d points (%0d line ends) and %0d empty results.",
                 n_points, n_final, n_empty);
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire
